>>> rtl/bsms_pkg.sv
package bsms_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int SIZE_BITS   = 10;
  localparam int SCALE_BITS  = 4;
  localparam int PIXEL_BITS  = 13;
  localparam int FORMAT_BITS = 3;
  localparam int GAP_BITS    = SIZE_BITS + SCALE_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = PIXEL_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_REQ_SIZE        = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REQ_SCALE       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REQ_PIXELS      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALLOWED_FORMATS = 2'd3;

  localparam logic [SIZE_BITS-1:0]   RESET_REQ_SIZE        = 10'd48;
  localparam logic [SCALE_BITS-1:0]  RESET_REQ_SCALE       = 4'd1;
  localparam logic [PIXEL_BITS-1:0]  RESET_REQ_PIXELS      = 13'd48;
  localparam logic [FORMAT_BITS-1:0] RESET_ALLOWED_FORMATS = 3'd7;

  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [SIZE_BITS-1:0]   size_t;
  typedef logic [SCALE_BITS-1:0]  scale_t;
  typedef logic [PIXEL_BITS-1:0]  pixel_t;
  typedef logic [FORMAT_BITS-1:0] format_t;
  typedef logic [GAP_BITS-1:0]    gap_t;

endpackage

>>> rtl/best_size_match_selector.sv
// Keeps the best-matching candidate of a list and reports it when the request
// marked last_candidate is processed. One request is accepted per cycle; each
// goes through an input register, one compare against the stored best, and
// lands in the result register; a result becomes valid as its last request
// leaves the input register. The block only stalls the input when a finished
// result is still waiting in the result register and another last request is
// ready to complete. Configuration is written through cfg_valid/cfg_ready,
// always ready, and must only change while no list is in progress.
module best_size_match_selector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bsms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bsms_pkg::INDEX_BITS-1:0]  cand_index,
  input  logic [bsms_pkg::FORMAT_BITS-1:0] cand_formats,
  input  logic                            has_subdir,
  input  logic [bsms_pkg::SIZE_BITS-1:0]   dir_size,
  input  logic [bsms_pkg::SCALE_BITS-1:0]  dir_scale,
  input  logic                            dir_scalable,
  input  logic [bsms_pkg::PIXEL_BITS-1:0]  min_pixels,
  input  logic [bsms_pkg::PIXEL_BITS-1:0]  max_pixels,
  input  logic                            last_candidate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [bsms_pkg::INDEX_BITS-1:0]  best_id,
  output logic                            best_unsized
);
  import bsms_pkg::*;

  size_t   req_size;
  scale_t  req_scale;
  pixel_t  req_pixels;
  format_t allowed_formats;

  logic    s_valid;
  index_t  s_index;
  format_t s_formats;
  logic    s_sized;
  size_t   s_size;
  scale_t  s_scale;
  logic    s_scalable;
  pixel_t  s_minp;
  pixel_t  s_maxp;
  logic    s_last;

  logic    best_valid;
  index_t  best_index;
  pixel_t  best_distance;
  size_t   best_size;
  scale_t  best_scale;
  logic    best_scalable;
  logic    best_is_unsized;
  logic    search_stopped;

  logic    best_valid_next;
  index_t  best_index_next;
  pixel_t  best_distance_next;
  size_t   best_size_next;
  scale_t  best_scale_next;
  logic    best_scalable_next;
  logic    best_is_unsized_next;
  logic    search_stopped_next;

  logic    s_advance;
  logic    take;
  pixel_t  cand_dist;
  gap_t    cand_gap;
  gap_t    best_gap;
  gap_t    cand_prod;
  gap_t    best_prod;
  logic    wins;
  logic    c_down;
  logic    b_down;
  logic    c_scale_eq;
  logic    b_scale_eq;

  assign cfg_ready = 1'b1;
  assign s_advance = s_valid && (!s_last || !out_valid || out_ready);
  assign in_ready  = !s_valid || s_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_size        <= RESET_REQ_SIZE;
      req_scale       <= RESET_REQ_SCALE;
      req_pixels      <= RESET_REQ_PIXELS;
      allowed_formats <= RESET_ALLOWED_FORMATS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REQ_SIZE:        req_size        <= cfg_data[SIZE_BITS-1:0];
        REG_REQ_SCALE:       req_scale       <= cfg_data[SCALE_BITS-1:0];
        REG_REQ_PIXELS:      req_pixels      <= cfg_data[PIXEL_BITS-1:0];
        REG_ALLOWED_FORMATS: allowed_formats <= cfg_data[FORMAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_index    <= cand_index;
      s_formats  <= cand_formats;
      s_sized    <= has_subdir;
      s_size     <= dir_size;
      s_scale    <= dir_scale;
      s_scalable <= dir_scalable;
      s_minp     <= min_pixels;
      s_maxp     <= max_pixels;
      s_last     <= last_candidate;
    end
  end

  // ranking against the stored best
  always_comb begin
    if (req_pixels < s_minp) begin
      cand_dist = s_minp - req_pixels;
    end else if (s_maxp < req_pixels) begin
      cand_dist = req_pixels - s_maxp;
    end else begin
      cand_dist = '0;
    end

    cand_prod = GAP_BITS'(s_size) * GAP_BITS'(s_scale);
    best_prod = GAP_BITS'(best_size) * GAP_BITS'(best_scale);
    cand_gap  = (cand_prod > GAP_BITS'(req_pixels)) ? cand_prod - GAP_BITS'(req_pixels)
                                                     : GAP_BITS'(req_pixels) - cand_prod;
    best_gap  = (best_prod > GAP_BITS'(req_pixels)) ? best_prod - GAP_BITS'(req_pixels)
                                                     : GAP_BITS'(req_pixels) - best_prod;

    c_down     = s_size >= req_size;
    b_down     = best_size >= req_size;
    c_scale_eq = s_scale == req_scale;
    b_scale_eq = best_scale == req_scale;

    if (cand_dist == '0 && best_distance != '0) begin
      wins = 1'b1;
    end else if (cand_dist != '0 && c_down && !b_down) begin
      wins = 1'b1;
    end else if (cand_dist != '0 && !c_down && b_down) begin
      wins = 1'b0;
    end else if (cand_dist != '0 && cand_dist < best_distance) begin
      wins = 1'b1;
    end else if (cand_dist != '0 && cand_dist > best_distance) begin
      wins = 1'b0;
    end else if (c_scale_eq && !b_scale_eq) begin
      wins = 1'b1;
    end else if (!c_scale_eq && b_scale_eq) begin
      wins = 1'b0;
    end else if (!s_scalable && best_scalable) begin
      wins = 1'b1;
    end else if (s_scalable && !best_scalable) begin
      wins = 1'b0;
    end else begin
      wins = cand_gap < best_gap;
    end
  end

  assign take = !search_stopped && ((s_formats & allowed_formats) != '0);

  always_comb begin
    best_valid_next      = best_valid;
    best_index_next      = best_index;
    best_distance_next   = best_distance;
    best_size_next       = best_size;
    best_scale_next      = best_scale;
    best_scalable_next   = best_scalable;
    best_is_unsized_next = best_is_unsized;
    search_stopped_next  = search_stopped;
    if (take) begin
      if (!s_sized) begin
        if (!best_valid) begin
          best_valid_next      = 1'b1;
          best_index_next      = s_index;
          best_is_unsized_next = 1'b1;
        end
        search_stopped_next = 1'b1;
      end else if (!best_valid || wins) begin
        best_valid_next      = 1'b1;
        best_index_next      = s_index;
        best_distance_next   = cand_dist;
        best_size_next       = s_size;
        best_scale_next      = s_scale;
        best_scalable_next   = s_scalable;
        best_is_unsized_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid      <= 1'b0;
      best_index      <= '0;
      best_distance   <= '0;
      best_size       <= '0;
      best_scale      <= '0;
      best_scalable   <= 1'b0;
      best_is_unsized <= 1'b0;
      search_stopped  <= 1'b0;
    end else if (s_advance) begin
      if (s_last) begin
        best_valid      <= 1'b0;
        best_index      <= '0;
        best_distance   <= '0;
        best_size       <= '0;
        best_scale      <= '0;
        best_scalable   <= 1'b0;
        best_is_unsized <= 1'b0;
        search_stopped  <= 1'b0;
      end else begin
        best_valid      <= best_valid_next;
        best_index      <= best_index_next;
        best_distance   <= best_distance_next;
        best_size       <= best_size_next;
        best_scale      <= best_scale_next;
        best_scalable   <= best_scalable_next;
        best_is_unsized <= best_is_unsized_next;
        search_stopped  <= search_stopped_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_advance && s_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_advance && s_last) begin
      found        <= best_valid_next;
      best_id      <= best_valid_next ? best_index_next : '0;
      best_unsized <= best_valid_next && best_is_unsized_next;
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsms_pkg::*;

  typedef struct packed {
    index_t  idx;
    format_t fmts;
    logic    sized;
    size_t   size;
    scale_t  scale;
    logic    scalable;
    pixel_t  minp;
    pixel_t  maxp;
    logic    last;
  } cand_t;

  typedef struct packed {
    logic   found;
    index_t id;
    logic   unsized;
  } pick_t;

  typedef struct packed {
    cand_t c;
    logic  typed;
    pick_t want;
  } row_t;

  localparam pick_t NO_PICK = '0;
  localparam int N_DIRECTED = 21;

  // idx, fmts, sized, size, scale, scalable, minp, maxp, last | typed, expected pick
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{16'h0000, 3'd0, 1, 10'd48, 4'd1, 0, 13'd0, 13'd4096, 1}, 1, '{0, 16'h0000, 0}},
    '{'{16'hFFFF, 3'd7, 1, 10'd48, 4'd1, 0, 13'd48, 13'd48, 1}, 1, '{1, 16'hFFFF, 0}},
    '{'{16'h0005, 3'd1, 0, 10'd0, 4'd0, 0, 13'd0, 13'd0, 0}, 0, NO_PICK},
    '{'{16'h0006, 3'd2, 1, 10'd48, 4'd1, 0, 13'd0, 13'd4096, 1}, 1, '{1, 16'h0005, 1}},
    '{'{16'h0007, 3'd4, 1, 10'd48, 4'd1, 0, 13'd40, 13'd60, 0}, 0, NO_PICK},
    '{'{16'h0008, 3'd7, 0, 10'd1023, 4'd15, 1, 13'd8191, 13'd8191, 0}, 0, NO_PICK},
    '{'{16'h0009, 3'd7, 1, 10'd48, 4'd1, 0, 13'd48, 13'd48, 1}, 1, '{1, 16'h0007, 0}},
    '{'{16'h000A, 3'd1, 1, 10'd32, 4'd1, 0, 13'd64, 13'd64, 0}, 0, NO_PICK},
    '{'{16'h000B, 3'd1, 1, 10'd64, 4'd1, 0, 13'd80, 13'd80, 0}, 0, NO_PICK},
    '{'{16'h000C, 3'd1, 1, 10'd96, 4'd1, 0, 13'd56, 13'd56, 0}, 0, NO_PICK},
    '{'{16'h000D, 3'd1, 1, 10'd48, 4'd2, 0, 13'd0, 13'd100, 0}, 0, NO_PICK},
    '{'{16'h000E, 3'd1, 1, 10'd48, 4'd1, 1, 13'd0, 13'd100, 0}, 0, NO_PICK},
    '{'{16'h000F, 3'd1, 1, 10'd48, 4'd1, 0, 13'd0, 13'd100, 0}, 0, NO_PICK},
    '{'{16'h0010, 3'd1, 1, 10'd40, 4'd1, 0, 13'd0, 13'd100, 0}, 0, NO_PICK},
    '{'{16'h0011, 3'd1, 1, 10'd48, 4'd1, 0, 13'd0, 13'd100, 0}, 0, NO_PICK},
    '{'{16'h0012, 3'd0, 1, 10'd48, 4'd1, 0, 13'd0, 13'd100, 1}, 0, NO_PICK},
    '{'{16'h0000, 3'd4, 1, 10'd1023, 4'd15, 1, 13'd8191, 13'd0, 1}, 1, '{1, 16'h0000, 0}},
    '{'{16'h1234, 3'd2, 1, 10'd1, 4'd1, 1, 13'd100, 13'd10, 0}, 0, NO_PICK},
    '{'{16'h5678, 3'd2, 1, 10'd512, 4'd8, 0, 13'd8191, 13'd8191, 0}, 0, NO_PICK},
    '{'{16'h2345, 3'd2, 0, 10'd0, 4'd0, 0, 13'd0, 13'd0, 1}, 0, NO_PICK},
    '{'{16'h5555, 3'd7, 0, 10'd0, 4'd0, 0, 13'd0, 13'd0, 1}, 1, '{1, 16'h5555, 1}}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  index_t                   cand_index;
  format_t                  cand_formats;
  logic                     has_subdir;
  size_t                    dir_size;
  scale_t                   dir_scale;
  logic                     dir_scalable;
  pixel_t                   min_pixels;
  pixel_t                   max_pixels;
  logic                     last_candidate;
  logic                     out_valid;
  logic                     out_ready;
  logic                     found;
  index_t                   best_id;
  logic                     best_unsized;

  best_size_match_selector dut (.*);

  // request settings mirrored from the register writes
  int      want_size;
  int      want_scale;
  int      want_pixels;
  format_t ok_formats;

  // running best of the current list
  bit     held_valid;
  index_t held_idx;
  int     held_dist;
  int     held_size;
  int     held_scale;
  bit     held_scalable;
  bit     held_unsized;
  bit     stopped;

  pick_t pending_picks[$];
  int    fail_count;
  int    send_idle_pct;
  int    recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_held();
    held_valid    = 1'b0;
    held_idx      = '0;
    held_dist     = 0;
    held_size     = 0;
    held_scale    = 0;
    held_scalable = 1'b0;
    held_unsized  = 1'b0;
    stopped       = 1'b0;
  endfunction

  function automatic int pixel_gap(int sz, int sc);
    int p;
    p = sz * sc;
    return (p > want_pixels) ? p - want_pixels : want_pixels - p;
  endfunction

  function automatic bit beats_held(int cand_dist, int sz, int sc, bit scl);
    bit c_down;
    bit b_down;
    bit c_match;
    bit b_match;
    if (cand_dist == 0) begin
      if (held_dist != 0) return 1'b1;
    end else begin
      c_down = sz >= want_size;
      b_down = held_size >= want_size;
      if (c_down && !b_down) return 1'b1;
      if (!c_down && b_down) return 1'b0;
      if (cand_dist < held_dist) return 1'b1;
      if (cand_dist > held_dist) return 1'b0;
    end
    c_match = sc == want_scale;
    b_match = held_scale == want_scale;
    if (c_match && !b_match) return 1'b1;
    if (!c_match && b_match) return 1'b0;
    if (!scl && held_scalable) return 1'b1;
    if (scl && !held_scalable) return 1'b0;
    return pixel_gap(sz, sc) < pixel_gap(held_size, held_scale);
  endfunction

  // advances the running best by one request; returns 1 when a pick is reported
  function automatic bit select_step(cand_t c, output pick_t r);
    int cand_dist;
    bit emit;
    if (!stopped && (c.fmts & ok_formats) != '0) begin
      if (!c.sized) begin
        if (!held_valid) begin
          held_valid   = 1'b1;
          held_idx     = c.idx;
          held_unsized = 1'b1;
        end
        stopped = 1'b1;
      end else begin
        if (want_pixels < int'(c.minp)) cand_dist = int'(c.minp) - want_pixels;
        else if (int'(c.maxp) < want_pixels) cand_dist = want_pixels - int'(c.maxp);
        else cand_dist = 0;
        if (!held_valid ||
            beats_held(cand_dist, int'(c.size), int'(c.scale), c.scalable)) begin
          held_valid    = 1'b1;
          held_idx      = c.idx;
          held_dist     = cand_dist;
          held_size     = int'(c.size);
          held_scale    = int'(c.scale);
          held_scalable = c.scalable;
          held_unsized  = 1'b0;
        end
      end
    end
    r.found   = held_valid;
    r.id      = held_valid ? held_idx : '0;
    r.unsized = held_valid && held_unsized;
    emit = c.last;
    if (emit) clear_held();
    return emit;
  endfunction

  function automatic pixel_t clip_px(int v);
    if (v < 0) return '0;
    if (v > 8191) return 13'd8191;
    return pixel_t'(v);
  endfunction

  function automatic cand_t random_cand(bit noise, bit last);
    cand_t       c;
    logic [63:0] bits;
    int          lo;
    if (noise) begin
      bits = {$urandom, $urandom};
      c = bits[61:0];
      c.last = c.last | last;
      return c;
    end
    c.idx   = index_t'($urandom_range(0, 65535));
    c.fmts  = format_t'($urandom_range(0, 7)) |
              (($urandom_range(0, 99) < 80) ? ok_formats : 3'd0);
    c.sized = $urandom_range(0, 99) < 92;
    case ($urandom_range(0, 3))
      0: c.size = size_t'(want_size);
      1: c.size = size_t'((want_size >> 1) + 1);
      2: c.size = size_t'((want_size * 2 > 1023) ? 1023 : want_size * 2);
      default: c.size = size_t'($urandom_range(1, 512));
    endcase
    c.scale    = $urandom_range(0, 1) ? scale_t'(want_scale) : scale_t'($urandom_range(1, 8));
    c.scalable = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 30) begin
      c.minp = clip_px(want_pixels - int'($urandom_range(0, 16)));
      c.maxp = clip_px(want_pixels + int'($urandom_range(0, 16)));
    end else begin
      lo = want_pixels + int'($urandom_range(0, 128)) - 64;
      c.minp = clip_px(lo);
      c.maxp = clip_px(lo + int'($urandom_range(0, 32)));
    end
    if ($urandom_range(0, 99) < 5) {c.minp, c.maxp} = {c.maxp, c.minp};
    c.last = last;
    return c;
  endfunction

  task automatic send_cand(input cand_t c, input bit typed, input pick_t want);
    pick_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cand_index     <= c.idx;
    cand_formats   <= c.fmts;
    has_subdir     <= c.sized;
    dir_size       <= c.size;
    dir_scale      <= c.scale;
    dir_scalable   <= c.scalable;
    min_pixels     <= c.minp;
    max_pixels     <= c.maxp;
    last_candidate <= c.last;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (select_step(c, r)) pending_picks.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] ridx, input int value);
    @(negedge clk);
    cfg_index <= ridx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (ridx)
      REG_REQ_SIZE:        want_size   = int'(value[SIZE_BITS-1:0]);
      REG_REQ_SCALE:       want_scale  = int'(value[SCALE_BITS-1:0]);
      REG_REQ_PIXELS:      want_pixels = int'(value[PIXEL_BITS-1:0]);
      REG_ALLOWED_FORMATS: ok_formats  = value[FORMAT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_request(input int sz, input int sc, input int px, input int fm);
    write_reg(REG_REQ_SIZE, sz);
    write_reg(REG_REQ_SCALE, sc);
    write_reg(REG_REQ_PIXELS, px);
    write_reg(REG_ALLOWED_FORMATS, fm);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // lets the pipeline empty out; lists always end with a last request
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (!rst && out_valid && out_ready) begin
      got.found   = found;
      got.id      = best_id;
      got.unsized = best_unsized;
      if (pending_picks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected pick: found=%0d id=%h unsized=%0d",
                   got.found, got.id, got.unsized);
      end else begin
        want = pending_picks.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("pick mismatch: exp found=%0d id=%h unsized=%0d, got found=%0d id=%h unsized=%0d",
                     want.found, want.id, want.unsized, got.found, got.id, got.unsized);
        end
      end
    end
  end

  initial begin
    int    n_sent;
    int    len;
    int    blk;
    int    sz;
    int    sc;
    bit    noisy;
    cand_t c;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_REQ_SIZE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    cand_index     = '0;
    cand_formats   = '0;
    has_subdir     = 1'b0;
    dir_size       = '0;
    dir_scale      = '0;
    dir_scalable   = 1'b0;
    min_pixels     = '0;
    max_pixels     = '0;
    last_candidate = 1'b0;
    out_ready      = 1'b0;
    fail_count     = 0;
    want_size      = int'(RESET_REQ_SIZE);
    want_scale     = int'(RESET_REQ_SCALE);
    want_pixels    = int'(RESET_REQ_PIXELS);
    ok_formats     = RESET_ALLOWED_FORMATS;
    clear_held();
    send_idle_pct  = 31;
    recv_idle_pct  = 66;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_cand(DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 31 : 0;
      for (int b = 0; b < 3; b++) begin
        blk = ph * 3 + b;
        wait_drained();
        case (blk)
          0: set_request(1, 1, 1, 1);
          1: set_request(512, 8, 4096, 7);
          2: set_request(1023, 15, 8191, 7);
          8: set_request(int'(RESET_REQ_SIZE), int'(RESET_REQ_SCALE), int'(RESET_REQ_PIXELS),
                         int'(RESET_ALLOWED_FORMATS));
          default: begin
            sz = $urandom_range(1, 512);
            sc = $urandom_range(1, 8);
            // one setting with no format allowed: every list comes back empty
            set_request(sz, sc, sz * sc, (blk == 5) ? 0 : $urandom_range(1, 7));
          end
        endcase
        n_sent = 0;
        while (n_sent < 110) begin
          noisy = $urandom_range(0, 99) < 15;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            c = random_cand(noisy, k == len - 1);
            send_cand(c, 1'b0, NO_PICK);
          end
          n_sent += len;
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
